// ===== rtl/bezier_point_and_normal_eval_core_defines.svh =====
// Assertion macros for the Bezier point and normal evaluator.
// Included by the top level; has no dependencies of its own.
`ifndef BEZIER_POINT_AND_NORMAL_EVAL_CORE_DEFINES_SVH
`define BEZIER_POINT_AND_NORMAL_EVAL_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BPN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
`define BPN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define BPN_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BPN_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/bpn_pkg.sv =====
// Shared widths, register codes and word types of the Bezier evaluator.
// No dependencies; every other RTL .sv file imports it.
`default_nettype none
package bpn_pkg;
    localparam int COORD_W   = 32;
    localparam int U_W       = 17;
    localparam int FRAC_W    = 16;
    localparam int ASP_W     = 16;
    localparam int TAN_W     = COORD_W + 1;
    localparam int NM_W      = 31;
    localparam int ROOT_W    = 32;
    localparam int DIV_FRAC  = 28;
    localparam int QUO_W     = DIV_FRAC + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [U_W-1:0]   U_ONE     = U_W'(1 << FRAC_W);
    localparam logic [ASP_W-1:0] ASP_RESET = ASP_W'(4096);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ASPECT_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ASPECT_Y = CFG_IDX_W'(1);

    typedef struct packed {
        logic signed [COORD_W-1:0] anchor_x;
        logic signed [COORD_W-1:0] anchor_y;
        logic signed [COORD_W-1:0] in_handle_x;
        logic signed [COORD_W-1:0] in_handle_y;
        logic signed [COORD_W-1:0] out_handle_x;
        logic signed [COORD_W-1:0] out_handle_y;
        logic signed [COORD_W-1:0] next_in_x;
        logic signed [COORD_W-1:0] next_in_y;
        logic signed [COORD_W-1:0] next_anchor_x;
        logic signed [COORD_W-1:0] next_anchor_y;
        logic [U_W-1:0]            param_u;
        logic                      open_end;
    } t_in_word;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] normal_x;
        logic signed [COORD_W-1:0] normal_y;
    } t_out_word;

    // Status flags of the normal path.
    typedef struct packed {
        logic zero;
        logic negx;
        logic negy;
    } t_nflags;

    // Side data carried along the pipeline units.
    typedef struct packed {
        logic                      open_end;
        logic signed [COORD_W-1:0] hix;
        logic signed [COORD_W-1:0] hiy;
    } t_lerp_tag;

    typedef struct packed {
        logic signed [TAN_W-1:0] tx;
        logic signed [TAN_W-1:0] ty;
    } t_tan_tag;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } t_pt_tag;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic [NM_W-1:0]           mx;
        logic [NM_W-1:0]           my;
        t_nflags                   flags;
    } t_sq_tag;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        t_nflags                   flags;
    } t_div_tag;
endpackage
`default_nettype wire

// ===== rtl/bpn_lerp.sv =====
// One de Casteljau level: a row of rounded Q1.16 interpolations, two stages.
// Depends on bpn_pkg.
`default_nettype none
module bpn_lerp #(
    parameter int LANES = 2,
    parameter int TAG_W = 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_vld,
    input  logic signed [bpn_pkg::COORD_W-1:0] i_a [LANES],
    input  logic signed [bpn_pkg::COORD_W-1:0] i_b [LANES],
    input  logic [bpn_pkg::U_W-1:0]            i_u,
    input  logic [TAG_W-1:0]                   i_tag,
    output logic                               o_vld,
    output logic signed [bpn_pkg::COORD_W-1:0] o_res [LANES],
    output logic [bpn_pkg::U_W-1:0]            o_u,
    output logic [TAG_W-1:0]                   o_tag
);
    import bpn_pkg::*;

    localparam int PROD_W = COORD_W + U_W + 2;
    localparam logic [PROD_W:0] RND = (PROD_W+1)'(1) << (FRAC_W - 1);

    logic signed [COORD_W:0]   diff [LANES];
    logic signed [PROD_W-1:0]  n_prod [LANES];
    logic signed [PROD_W-1:0]  r_prod [LANES];
    logic signed [COORD_W-1:0] r_a [LANES];
    logic [PROD_W:0]           rnd [LANES];
    logic signed [COORD_W-1:0] n_res [LANES];
    logic signed [COORD_W-1:0] r_res [LANES];
    logic                      r_vld1, r_vld2;
    logic [U_W-1:0]            r_u1, r_u2;
    logic [TAG_W-1:0]          r_tag1, r_tag2;

    // Stage one: difference times u.
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            diff[k]   = {i_b[k][COORD_W-1], i_b[k]} - {i_a[k][COORD_W-1], i_a[k]};
            n_prod[k] = diff[k] * $signed({1'b0, i_u});
        end
    end

    // Stage two: round half up, floor shift, add the start value.
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            rnd[k]   = {r_prod[k][PROD_W-1], r_prod[k]} + RND;
            n_res[k] = r_a[k] + rnd[k][FRAC_W +: COORD_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < LANES; k++) begin
                r_prod[k] <= n_prod[k];
                r_a[k]    <= i_a[k];
                r_res[k]  <= n_res[k];
            end
            r_u1   <= i_u;
            r_u2   <= r_u1;
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
        end
    end

    assign o_vld = r_vld2;
    assign o_res = r_res;
    assign o_u   = r_u2;
    assign o_tag = r_tag2;
endmodule
`default_nettype wire

// ===== rtl/bpn_norm.sv =====
// Aspect-scaled tangent magnitudes, the larger shifted to [2^30, 2^31), five stages.
// Depends on bpn_pkg.
`default_nettype none
module bpn_norm #(
    parameter int TAG_W = 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_vld,
    input  logic signed [bpn_pkg::TAN_W-1:0] i_tx,
    input  logic signed [bpn_pkg::TAN_W-1:0] i_ty,
    input  logic [bpn_pkg::ASP_W-1:0]        i_ax,
    input  logic [bpn_pkg::ASP_W-1:0]        i_ay,
    input  logic [TAG_W-1:0]                 i_tag,
    output logic                             o_vld,
    output logic [bpn_pkg::NM_W-1:0]         o_mx,
    output logic [bpn_pkg::NM_W-1:0]         o_my,
    output bpn_pkg::t_nflags                 o_flags,
    output logic [TAG_W-1:0]                 o_tag
);
    import bpn_pkg::*;

    localparam int MAG_W  = TAN_W + ASP_W;
    localparam int SH_W   = MAG_W + NM_W - 1;
    localparam int CH_W   = 16;
    localparam int CHUNKS = 4;
    localparam int PAD_W  = CH_W * CHUNKS;

    logic [TAN_W-1:0]  abs_x, abs_y;
    logic [MAG_W-1:0]  n1_mx, n1_my, r1_mx, r1_my, r2_mx, r2_my, r3_mx, r3_my;
    logic [PAD_W-1:0]  orv;
    logic [CH_W-1:0]   chunk;
    logic [CHUNKS-1:0] n2_nz, r2_nz;
    logic [3:0]        n2_loc [CHUNKS];
    logic [3:0]        r2_loc [CHUNKS];
    logic [5:0]        n3_msb, r3_msb;
    logic              n3_zero, r3_zero;
    logic [SH_W-1:0]   n4_wx, n4_wy, r4_wx, r4_wy;
    logic [3:0]        r4_lo;
    logic [NM_W-1:0]   r5_mx, r5_my;
    logic              r1_negx, r1_negy, r2_negx, r2_negy, r3_negx, r3_negy;
    t_nflags           r4_flags, r5_flags;
    logic [4:0]        r_vld;
    logic [TAG_W-1:0]  r_tag [5];

    // Stage one: magnitudes times the cross aspect, and the output signs.
    always_comb begin
        abs_x = i_tx[TAN_W-1] ? TAN_W'(-i_tx) : TAN_W'(i_tx);
        abs_y = i_ty[TAN_W-1] ? TAN_W'(-i_ty) : TAN_W'(i_ty);
        n1_mx = MAG_W'(abs_y) * MAG_W'(i_ay);
        n1_my = MAG_W'(abs_x) * MAG_W'(i_ax);
    end

    // Stage two: leading one of each 16-bit chunk of the combined magnitude.
    always_comb begin
        orv = PAD_W'(r1_mx | r1_my);
        for (int c = 0; c < CHUNKS; c++) begin
            chunk     = orv[c*CH_W +: CH_W];
            n2_nz[c]  = |chunk;
            n2_loc[c] = 4'd0;
            for (int b = 0; b < CH_W; b++) begin
                if (chunk[b]) begin
                    n2_loc[c] = 4'(b);
                end
            end
        end
    end

    // Stage three: leading one position of the whole word.
    always_comb begin
        n3_zero = ~|r2_nz;
        if (r2_nz[3]) begin
            n3_msb = {2'd3, r2_loc[3]};
        end else if (r2_nz[2]) begin
            n3_msb = {2'd2, r2_loc[2]};
        end else if (r2_nz[1]) begin
            n3_msb = {2'd1, r2_loc[1]};
        end else begin
            n3_msb = {2'd0, r2_loc[0]};
        end
    end

    // Stage four: coarse shift; the word is pre-scaled by 2^30 so one right shift
    // covers both directions and truncates like the repeated halving.
    always_comb begin
        n4_wx = {r3_mx, 30'b0} >> {r3_msb[5:4], 4'b0};
        n4_wy = {r3_my, 30'b0} >> {r3_msb[5:4], 4'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mx    <= n1_mx;
            r1_my    <= n1_my;
            r1_negx  <= !i_ty[TAN_W-1] && (i_ty != '0);
            r1_negy  <= i_tx[TAN_W-1];
            r2_mx    <= r1_mx;
            r2_my    <= r1_my;
            r2_nz    <= n2_nz;
            r2_loc   <= n2_loc;
            r2_negx  <= r1_negx;
            r2_negy  <= r1_negy;
            r3_mx    <= r2_mx;
            r3_my    <= r2_my;
            r3_msb   <= n3_msb;
            r3_zero  <= n3_zero;
            r3_negx  <= r2_negx;
            r3_negy  <= r2_negy;
            r4_wx    <= n4_wx;
            r4_wy    <= n4_wy;
            r4_lo    <= r3_msb[3:0];
            r4_flags <= '{zero: r3_zero, negx: r3_negx, negy: r3_negy};
            r5_mx    <= NM_W'(r4_wx >> r4_lo);
            r5_my    <= NM_W'(r4_wy >> r4_lo);
            r5_flags <= r4_flags;
            r_tag[0] <= i_tag;
            for (int s = 1; s < 5; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
        end
    end

    assign o_vld   = r_vld[4];
    assign o_mx    = r5_mx;
    assign o_my    = r5_my;
    assign o_flags = r5_flags;
    assign o_tag   = r_tag[4];
endmodule
`default_nettype wire

// ===== rtl/bpn_isqrt.sv =====
// Vector length: squares, sum, then one digit-by-digit root step per stage.
// Depends on bpn_pkg.
`default_nettype none
module bpn_isqrt #(
    parameter int TAG_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [bpn_pkg::NM_W-1:0]    i_mx,
    input  logic [bpn_pkg::NM_W-1:0]    i_my,
    input  logic [TAG_W-1:0]            i_tag,
    output logic                        o_vld,
    output logic [bpn_pkg::ROOT_W-1:0]  o_len,
    output logic [TAG_W-1:0]            o_tag
);
    import bpn_pkg::*;

    localparam int SQ_W = 2 * NM_W;
    localparam int V_W  = 2 * ROOT_W;
    localparam int ITER = ROOT_W;

    logic [SQ_W-1:0]  r_sx, r_sy;
    logic             r_sq_vld;
    logic [TAG_W-1:0] r_sq_tag;
    logic [V_W-1:0]   r_rem [ITER+1];
    logic [V_W-1:0]   r_res [ITER+1];
    logic             r_vld [ITER+1];
    logic [TAG_W-1:0] r_tag [ITER+1];

    // Squares, then their sum seeds the root recurrence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= 1'b0;
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_sq_vld <= i_vld;
            r_vld[0] <= r_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx     <= SQ_W'(i_mx) * SQ_W'(i_mx);
            r_sy     <= SQ_W'(i_my) * SQ_W'(i_my);
            r_sq_tag <= i_tag;
            r_rem[0] <= V_W'(r_sx) + V_W'(r_sy);
            r_res[0] <= '0;
            r_tag[0] <= r_sq_tag;
        end
    end

    // One root step per stage, testing bit weights from 2^62 down.
    for (genvar i = 0; i < ITER; i++) begin : g_step
        localparam logic [V_W-1:0] BIT = V_W'(1) << (V_W - 2 - 2 * i);
        logic [V_W-1:0] trial, n_rem, n_res;

        always_comb begin
            trial = r_res[i] + BIT;
            if (r_rem[i] >= trial) begin
                n_rem = r_rem[i] - trial;
                n_res = (r_res[i] >> 1) + BIT;
            end else begin
                n_rem = r_rem[i];
                n_res = r_res[i] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[i+1] <= r_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i+1] <= n_rem;
                r_res[i+1] <= n_res;
                r_tag[i+1] <= r_tag[i];
            end
        end
    end

    assign o_vld = r_vld[ITER];
    assign o_len = r_res[ITER][ROOT_W-1:0];
    assign o_tag = r_tag[ITER];
endmodule
`default_nettype wire

// ===== rtl/bpn_div.sv =====
// Two-lane rounded divider m * 2^28 / (len * aspect), one quotient bit per stage.
// Depends on bpn_pkg.
`default_nettype none
module bpn_div #(
    parameter int TAG_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [bpn_pkg::NM_W-1:0]    i_m [2],
    input  logic [bpn_pkg::ASP_W-1:0]   i_asp [2],
    input  logic [bpn_pkg::ROOT_W-1:0]  i_len,
    input  logic [TAG_W-1:0]            i_tag,
    output logic                        o_vld,
    output logic [bpn_pkg::QUO_W-1:0]   o_q [2],
    output logic [TAG_W-1:0]            o_tag
);
    import bpn_pkg::*;

    localparam int DEN_W = ROOT_W + ASP_W;
    localparam int NUM_W = NM_W + DIV_FRAC + 1;
    localparam int CMP_W = DEN_W + QUO_W;

    logic [DEN_W-1:0] n_den [2];
    logic [NUM_W-1:0] n_num [2];
    logic [DEN_W-1:0] r_den [QUO_W+1][2];
    logic [NUM_W-1:0] r_rem [QUO_W+1][2];
    logic [QUO_W-1:0] r_q   [QUO_W+1][2];
    logic             r_vld [QUO_W+1];
    logic [TAG_W-1:0] r_tag [QUO_W+1];

    // Divisor and numerator with half the divisor added for rounding.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_den[l] = DEN_W'(i_len) * DEN_W'(i_asp[l]);
            n_num[l] = NUM_W'({i_m[l], DIV_FRAC'(0)}) + NUM_W'(n_den[l] >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 2; l++) begin
                r_den[0][l] <= n_den[l];
                r_rem[0][l] <= n_num[l];
                r_q[0][l]   <= '0;
            end
            r_tag[0] <= i_tag;
        end
    end

    // Restoring steps, most significant quotient bit first.
    for (genvar s = 0; s < QUO_W; s++) begin : g_step
        localparam int SH = QUO_W - 1 - s;
        logic [CMP_W-1:0] shd [2];
        logic [NUM_W-1:0] n_rem [2];
        logic [QUO_W-1:0] n_q [2];

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                shd[l] = CMP_W'(r_den[s][l]) << SH;
                if (CMP_W'(r_rem[s][l]) >= shd[l]) begin
                    n_rem[l] = r_rem[s][l] - NUM_W'(shd[l]);
                    n_q[l]   = r_q[s][l] | (QUO_W'(1) << SH);
                end else begin
                    n_rem[l] = r_rem[s][l];
                    n_q[l]   = r_q[s][l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 2; l++) begin
                    r_den[s+1][l] <= r_den[s][l];
                    r_rem[s+1][l] <= n_rem[l];
                    r_q[s+1][l]   <= n_q[l];
                end
                r_tag[s+1] <= r_tag[s];
            end
        end
    end

    assign o_vld = r_vld[QUO_W];
    assign o_q   = r_q[QUO_W];
    assign o_tag = r_tag[QUO_W];
endmodule
`default_nettype wire

// ===== rtl/bezier_point_and_normal_eval_core.sv =====
// Cubic Bezier point and aspect-corrected unit normal, fully pipelined.
// The pipe holds three interpolation levels of two stages, five normalize
// stages, 34 root stages, 30 divide stages and the output register.
// Throughput is one word per cycle; the whole pipe holds while the output stalls.
// Synchronous active-low reset empties the pipe and sets both aspects to 4096.
`default_nettype none
`include "bezier_point_and_normal_eval_core_defines.svh"
module bezier_point_and_normal_eval_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  bpn_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output bpn_pkg::t_out_word             o_out_word,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bpn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bpn_pkg::ASP_W-1:0]      i_cfg_data
);
    import bpn_pkg::*;

    localparam int NRM_MAX = 1 << DIV_FRAC;

    logic              en;
    logic [ASP_W-1:0]  r_asp_x, r_asp_y, asp_x, asp_y;
    logic [U_W-1:0]    u_sat;
    t_lerp_tag         tag0, tag1, tag2;
    logic signed [COORD_W-1:0] a1 [6], b1 [6], q [6];
    logic signed [COORD_W-1:0] a2 [4], b2 [4], r [4];
    logic signed [COORD_W-1:0] a3 [2], b3 [2], pt [2];
    logic [U_W-1:0]    u1, u2, u3;
    logic              v1, v2, v3, v4, v5, v6;
    t_tan_tag          tan_in, tan_out;
    t_pt_tag           pt_tag;
    t_pt_tag           norm_pt;
    logic [NM_W-1:0]   mx, my;
    t_nflags           nflags;
    t_sq_tag           sq_in, sq_out;
    logic [ROOT_W-1:0] len;
    logic [NM_W-1:0]   dm [2];
    logic [ASP_W-1:0]  dasp [2];
    t_div_tag          div_in;
    t_div_tag          dtag;
    logic [QUO_W-1:0]  qq [2];
    logic              r_out_valid;
    t_out_word         r_out_word, n_out_word;
    logic [COORD_W-1:0] qx, qy;
    logic              nx_in_range;
    logic              cfg_wr_y;

    // Whole pipe moves whenever the output register can take a word.
    assign en          = !r_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    // Aspect registers; zero acts as one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asp_x <= ASP_RESET;
            r_asp_y <= ASP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ASPECT_X: r_asp_x <= i_cfg_data;
                CFG_ASPECT_Y: r_asp_y <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign asp_x = (r_asp_x == '0) ? ASP_W'(1) : r_asp_x;
    assign asp_y = (r_asp_y == '0) ? ASP_W'(1) : r_asp_y;

    // Input word: saturate u; an open end collapses every control point onto the anchor.
    always_comb begin
        u_sat = (i_in_word.param_u > U_ONE) ? U_ONE : i_in_word.param_u;
        tag0  = '{open_end: i_in_word.open_end, hix: i_in_word.in_handle_x,
                  hiy: i_in_word.in_handle_y};
        a1[0] = i_in_word.anchor_x;
        a1[3] = i_in_word.anchor_y;
        if (i_in_word.open_end) begin
            a1[1] = i_in_word.anchor_x;
            a1[2] = i_in_word.anchor_x;
            b1[2] = i_in_word.anchor_x;
            a1[4] = i_in_word.anchor_y;
            a1[5] = i_in_word.anchor_y;
            b1[5] = i_in_word.anchor_y;
        end else begin
            a1[1] = i_in_word.out_handle_x;
            a1[2] = i_in_word.next_in_x;
            b1[2] = i_in_word.next_anchor_x;
            a1[4] = i_in_word.out_handle_y;
            a1[5] = i_in_word.next_in_y;
            b1[5] = i_in_word.next_anchor_y;
        end
        b1[0] = a1[1];
        b1[1] = a1[2];
        b1[3] = a1[4];
        b1[4] = a1[5];
    end

    bpn_lerp #(.LANES(6), .TAG_W($bits(t_lerp_tag))) u_lerp1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(i_in_valid && en),
        .i_a(a1), .i_b(b1), .i_u(u_sat), .i_tag(tag0),
        .o_vld(v1), .o_res(q), .o_u(u1), .o_tag(tag1)
    );

    // Second level: r0 and r1.
    always_comb begin
        a2[0] = q[0]; b2[0] = q[1];
        a2[1] = q[1]; b2[1] = q[2];
        a2[2] = q[3]; b2[2] = q[4];
        a2[3] = q[4]; b2[3] = q[5];
    end

    bpn_lerp #(.LANES(4), .TAG_W($bits(t_lerp_tag))) u_lerp2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(v1),
        .i_a(a2), .i_b(b2), .i_u(u1), .i_tag(tag1),
        .o_vld(v2), .o_res(r), .o_u(u2), .o_tag(tag2)
    );

    // Third level gives the point; the tangent is formed beside it.
    always_comb begin
        a3[0] = r[0]; b3[0] = r[1];
        a3[1] = r[2]; b3[1] = r[3];
        if (tag2.open_end) begin
            tan_in.tx = {r[0][COORD_W-1], r[0]} - {tag2.hix[COORD_W-1], tag2.hix};
            tan_in.ty = {r[2][COORD_W-1], r[2]} - {tag2.hiy[COORD_W-1], tag2.hiy};
        end else begin
            tan_in.tx = {r[1][COORD_W-1], r[1]} - {r[0][COORD_W-1], r[0]};
            tan_in.ty = {r[3][COORD_W-1], r[3]} - {r[2][COORD_W-1], r[2]};
        end
    end

    bpn_lerp #(.LANES(2), .TAG_W($bits(t_tan_tag))) u_lerp3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(v2),
        .i_a(a3), .i_b(b3), .i_u(u2), .i_tag(tan_in),
        .o_vld(v3), .o_res(pt), .o_u(u3), .o_tag(tan_out)
    );

    assign pt_tag = '{px: pt[0], py: pt[1]};

    bpn_norm #(.TAG_W($bits(t_pt_tag))) u_norm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(v3 && (u3 <= U_ONE)),
        .i_tx(tan_out.tx), .i_ty(tan_out.ty), .i_ax(asp_x), .i_ay(asp_y),
        .i_tag(pt_tag),
        .o_vld(v4), .o_mx(mx), .o_my(my), .o_flags(nflags), .o_tag(norm_pt)
    );

    // Side data for the root stage.
    assign sq_in = '{px: norm_pt.px, py: norm_pt.py, mx: mx, my: my, flags: nflags};

    bpn_isqrt #(.TAG_W($bits(t_sq_tag))) u_isqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(v4),
        .i_mx(mx), .i_my(my), .i_tag(sq_in),
        .o_vld(v5), .o_len(len), .o_tag(sq_out)
    );

    always_comb begin
        dm[0]   = sq_out.mx;
        dm[1]   = sq_out.my;
        dasp[0] = asp_x;
        dasp[1] = asp_y;
    end

    assign div_in = '{px: sq_out.px, py: sq_out.py, flags: sq_out.flags};

    bpn_div #(.TAG_W($bits(t_div_tag))) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(v5),
        .i_m(dm), .i_asp(dasp), .i_len(len),
        .i_tag(div_in),
        .o_vld(v6), .o_q(qq), .o_tag(dtag)
    );

    // Signs and the zero-tangent case.
    always_comb begin
        qx = COORD_W'(qq[0]);
        qy = COORD_W'(qq[1]);
        n_out_word.point_x  = dtag.px;
        n_out_word.point_y  = dtag.py;
        if (dtag.flags.zero) begin
            n_out_word.normal_x = '0;
            n_out_word.normal_y = '0;
        end else begin
            n_out_word.normal_x = dtag.flags.negx ? -qx : qx;
            n_out_word.normal_y = dtag.flags.negy ? -qy : qy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Terms for the checks below.
    assign nx_in_range = (o_out_word.normal_x <= NRM_MAX) && (o_out_word.normal_x >= -NRM_MAX);
    assign cfg_wr_y    = i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_ASPECT_Y);

    `BPN_ASSERT_IMP(a_normal_x_bound, i_clk, i_rst_n, o_out_valid, nx_in_range)
    `BPN_ASSERT_IMP(a_stall_holds_pipe, i_clk, i_rst_n, o_out_valid && !i_out_ready, !o_in_ready)
    `BPN_ASSERT_NXT(a_aspect_y_write, i_clk, i_rst_n, cfg_wr_y, r_asp_y == $past(i_cfg_data))
endmodule
`default_nettype wire
